// ===== hw/rtl/c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// c2p_pkg
// Types, constants and tables shared by the cartesian-to-polar CORDIC pipeline.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 40 - DATA_W;
    localparam int X_W       = 42;
    localparam int Z_W       = 32;
    localparam int ANG_SHIFT = Z_W - DATA_W;
    localparam int GAIN_W    = 20;
    localparam int MAX_ITER  = 24;
    localparam int MIN_ITER  = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] coord_x;
        logic signed [DATA_W-1:0] coord_y;
    } point_t;

    typedef struct packed {
        logic        [DATA_W-1:0] magnitude;
        logic signed [DATA_W-1:0] angle;
    } polar_t;

    // vector in flight through the rotation stages
    typedef struct packed {
        logic                  zero;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic        [Z_W-1:0] z;
    } vec_t;

    // atan(2^-i), full circle = 2^32
    localparam logic [Z_W-1:0] ATAN_TABLE [MAX_ITER] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // inverse CORDIC gain in Q20 for a given rotation count
    function automatic logic [GAIN_W-1:0] inv_gain(input int n);
        logic [GAIN_W-1:0] g;
        case (n)
            8:       g = 20'd636757;
            9:       g = 20'd636752;
            default: g = 20'd636751;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/cartesian_to_polar.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Pipelined CORDIC vectoring: point (x, y) to magnitude and binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   A point is taken on the clock edge where start is high and busy is low.
//   busy is set in reset and cleared by the clock once reset is released; after that a
//   point can be taken on every clock.
//   Each point gives one result beat on result, marked by done for exactly
//   one cycle. The receiver has no backpressure; results must be taken.
//   From accept to done a point passes the input register, one register per
//   micro-rotation and two registers for gain removal.
//   Throughput: one point per cycle, set by the fully unrolled rotation
//   stages and the split gain multiply.
//   magnitude: unsigned, rounded to nearest, clamped to 16 bits.
//   angle: signed, pi = 32768 units, pi wraps to the most negative code.
//   The origin gives magnitude 0 and angle 0.
//   Reset clears all valid bits; points in flight are dropped.
// ----------------------------------------------------------------------------
module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  point_t point,
    output logic   done,
    output polar_t result
);

    localparam int                NUM_ROT = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
    localparam int                LATENCY = NUM_ROT + 3;
    localparam logic [GAIN_W-1:0] GAIN    = inv_gain(NUM_ROT);

    logic busy_reg;
    logic accept;
    logic valid_chain [NUM_ROT+1];
    vec_t vec_chain   [NUM_ROT+1];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    c2p_prerotate u_prerotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (accept),
        .src_point (point),
        .dst_valid (valid_chain[0]),
        .dst_vec   (vec_chain[0])
    );

    for (genvar i = 0; i < NUM_ROT; i++)
    begin : g_rot
        c2p_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (valid_chain[i]),
            .src_vec   (vec_chain[i]),
            .dst_valid (valid_chain[i+1]),
            .dst_vec   (vec_chain[i+1])
        );
    end

    c2p_scale #(
        .GAIN (GAIN)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (valid_chain[NUM_ROT]),
        .src_vec   (vec_chain[NUM_ROT]),
        .done      (done),
        .result    (result)
    );

    // every accepted point comes out after a fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted point did not produce a result");

    // no result without a matching accept
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without accepted point");

    // origin maps to zero magnitude and zero angle
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && point.coord_x == '0 && point.coord_y == '0)
        |-> ##LATENCY (result.magnitude == '0 && result.angle == '0))
        else $error("origin gave nonzero result");

endmodule

// ===== hw/rtl/c2p_prerotate.sv =====
// ----------------------------------------------------------------------------
// c2p_prerotate
// Input register: folds the left half plane by pi and scales to fixed point.
// ----------------------------------------------------------------------------
module c2p_prerotate
    import c2p_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   src_valid,
    input  point_t src_point,
    output logic   dst_valid,
    output vec_t   dst_vec
);

    logic                  valid_reg;
    vec_t                  vec_reg;
    vec_t                  vec_next;
    logic signed [X_W-1:0] x_ext;
    logic signed [X_W-1:0] y_ext;

    always_comb
    begin
        x_ext = {{(X_W-DATA_W){src_point.coord_x[DATA_W-1]}}, src_point.coord_x};
        y_ext = {{(X_W-DATA_W){src_point.coord_y[DATA_W-1]}}, src_point.coord_y};
        vec_next.zero = (src_point.coord_x == '0) && (src_point.coord_y == '0);
        if (src_point.coord_x[DATA_W-1])
        begin
            vec_next.x = (-x_ext) <<< FRAC_BITS;
            vec_next.y = (-y_ext) <<< FRAC_BITS;
            vec_next.z = {1'b1, {(Z_W-1){1'b0}}};
        end
        else
        begin
            vec_next.x = x_ext <<< FRAC_BITS;
            vec_next.y = y_ext <<< FRAC_BITS;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign dst_valid = valid_reg;
    assign dst_vec   = vec_reg;

endmodule

// ===== hw/rtl/c2p_stage.sv =====
// ----------------------------------------------------------------------------
// c2p_stage
// One registered CORDIC vectoring micro-rotation, shift fixed by STAGE.
// ----------------------------------------------------------------------------
module c2p_stage
    import c2p_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    input  vec_t src_vec,
    output logic dst_valid,
    output vec_t dst_vec
);

    logic                  valid_reg;
    vec_t                  vec_reg;
    vec_t                  vec_next;
    logic signed [X_W-1:0] x_cur;
    logic signed [X_W-1:0] y_cur;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;

    always_comb
    begin
        x_cur = src_vec.x;
        y_cur = src_vec.y;
        xs    = x_cur >>> STAGE;
        ys    = y_cur >>> STAGE;
        vec_next.zero = src_vec.zero;
        if (!y_cur[X_W-1])
        begin
            vec_next.x = x_cur + ys;
            vec_next.y = y_cur - xs;
            vec_next.z = src_vec.z + ATAN_TABLE[STAGE];
        end
        else
        begin
            vec_next.x = x_cur - ys;
            vec_next.y = y_cur + xs;
            vec_next.z = src_vec.z - ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign dst_valid = valid_reg;
    assign dst_vec   = vec_reg;

endmodule

// ===== hw/rtl/c2p_scale.sv =====
// ----------------------------------------------------------------------------
// c2p_scale
// Gain removal and rounding: split partial products, then sum, round, clamp.
// ----------------------------------------------------------------------------
module c2p_scale
    import c2p_pkg::*;
#(
    parameter logic [GAIN_W-1:0] GAIN = 20'd636751
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   src_valid,
    input  vec_t   src_vec,
    output logic   done,
    output polar_t result
);

    localparam int LO_W   = 20;
    localparam int HI_W   = X_W - 1 - LO_W;
    localparam int PHI_W  = HI_W + GAIN_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int SUM_W  = PHI_W + LO_W + 1;
    localparam int RSHIFT = FRAC_BITS + 20;
    localparam int MAG_W  = SUM_W - RSHIFT;

    logic              valid_a_reg;
    logic              zero_a_reg;
    logic [PHI_W-1:0]  phi_a_reg;
    logic [PLO_W-1:0]  plo_a_reg;
    logic [Z_W-1:0]    z_a_reg;
    logic [PHI_W-1:0]  phi_next;
    logic [PLO_W-1:0]  plo_next;
    logic [Z_W-1:0]    z_next;

    logic              done_reg;
    polar_t            result_reg;
    polar_t            result_next;
    logic [SUM_W-1:0]  sum;
    logic [MAG_W-1:0]  mag_full;

    always_comb
    begin
        phi_next = PHI_W'(src_vec.x[X_W-2:LO_W]) * PHI_W'(GAIN);
        plo_next = PLO_W'(src_vec.x[LO_W-1:0]) * PLO_W'(GAIN);
        z_next   = src_vec.z + (Z_W'(1) << (ANG_SHIFT - 1));
    end

    always_comb
    begin
        sum = {1'b0, phi_a_reg, {LO_W{1'b0}}} + SUM_W'(plo_a_reg)
            + (SUM_W'(1) << (RSHIFT - 1));
        mag_full = sum[SUM_W-1:RSHIFT];
        if (zero_a_reg)
        begin
            result_next.magnitude = '0;
            result_next.angle     = '0;
        end
        else
        begin
            if (mag_full > MAG_W'({DATA_W{1'b1}}))
            begin
                result_next.magnitude = '1;
            end
            else
            begin
                result_next.magnitude = mag_full[DATA_W-1:0];
            end
            result_next.angle = z_a_reg[Z_W-1:ANG_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_a_reg <= src_valid;
            done_reg    <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_a_reg <= src_vec.zero;
        phi_a_reg  <= phi_next;
        plo_a_reg  <= plo_next;
        z_a_reg    <= z_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/cartesian_to_polar_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_tb
// Self-checking bench for the pipelined CORDIC cartesian-to-polar converter.
// A directed table hits the origin, the axes, the corners and the negative
// x axis, then random points follow. The sender works in bursts with random
// gaps. Typed rows carry their result, other points run through a bit-exact
// CORDIC predictor here; every done beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module cartesian_to_polar_tb;
    import c2p_pkg::*;

    localparam int ROTATIONS   = 16;
    localparam int LATENCY     = ROTATIONS + 3;
    localparam int RANDOM_PTS  = 950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // atan(2^-i), full circle = 2^32
    localparam logic [31:0] ARCTAN_LUT [ROTATIONS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct {
        int x;
        int y;
        bit typed;
        int mag;
        int ang;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{0, 0, 1, 0, 0},
        '{1, 0, 1, 1, 0},
        '{-1, 0, 1, 1, -32768},
        '{32767, 0, 1, 32767, 0},
        '{-32768, 0, 1, 32768, -32768},
        '{0, 32767, 1, 32767, 16384},
        '{0, -32768, 1, 32768, -16384},
        '{-32768, -32768, 1, 46341, -24576},
        '{32767, 32767, 0, 0, 0},
        '{-32768, 32767, 0, 0, 0},
        '{32767, -32768, 0, 0, 0},
        '{0, 1, 0, 0, 0},
        '{0, -1, 0, 0, 0},
        '{1, 1, 0, 0, 0},
        '{-1, 1, 0, 0, 0},
        '{-1, -1, 0, 0, 0},
        '{1, -1, 0, 0, 0},
        '{-32768, 1, 0, 0, 0},
        '{-32768, -1, 0, 0, 0},
        '{-5, 0, 0, 0, 0},
        '{21845, -21846, 0, 0, 0},
        '{-21846, 21845, 0, 0, 0},
        '{3, 4, 0, 0, 0},
        '{-3, -4, 0, 0, 0}
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    point_t point = '0;
    logic   done;
    polar_t result;

    // expectation riding along with the point being offered
    bit     typed_ok = 1'b0;
    polar_t typed_want = '0;

    polar_t            polar_q [$];
    longint unsigned   gain_q20;
    int                burst_left = 0;
    int                accepted = 0;
    int                checked = 0;
    int                fault_count = 0;
    int                cycle_count = 0;

    cartesian_to_polar #(
        .ITERATIONS(ROTATIONS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .point  (point),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v   -= res + probe;
                res  = (res >> 1) + probe;
            end
            else
                res >>= 1;
            probe >>= 2;
        end
        return res;
    endfunction

    // 1/K in Q20, built up in Q30 one rotation at a time
    function automatic longint unsigned cordic_inv_gain();
        longint unsigned g;
        longint unsigned s;
        int i;
        g = 64'd1 << 30;
        for (i = 0; i < ROTATIONS; i++)
        begin
            s = floor_sqrt((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
            g = ((g << 30) + s / 2) / s;
        end
        return (g + 512) >> 10;
    endfunction

    function automatic polar_t cordic_polar(input point_t p);
        longint signed   xv;
        longint signed   yv;
        longint signed   xs;
        longint signed   ys;
        longint unsigned prod;
        logic [31:0]     zacc;
        polar_t          r;
        int              i;
        xv   = p.coord_x;
        yv   = p.coord_y;
        zacc = '0;
        if (xv == 0 && yv == 0)
            return '0;
        if (xv < 0)
        begin
            xv   = -xv;
            yv   = -yv;
            zacc = 32'h8000_0000;
        end
        xv = xv <<< FRAC_BITS;
        yv = yv <<< FRAC_BITS;
        for (i = 0; i < ROTATIONS; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0)
            begin
                xv   += ys;
                yv   -= xs;
                zacc += ARCTAN_LUT[i];
            end
            else
            begin
                xv   -= ys;
                yv   += xs;
                zacc -= ARCTAN_LUT[i];
            end
        end
        prod = $unsigned(xv) * gain_q20 + (64'd1 << (FRAC_BITS + 19));
        prod = prod >> (FRAC_BITS + 20);
        r.magnitude = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
        zacc += 32'd1 << 15;
        r.angle = zacc[31:16];
        return r;
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     kind;
        int     corner [6];
        corner = '{-32768, -32767, -1, 0, 1, 32767};
        kind   = $urandom_range(0, 9);
        p.coord_x = 16'($urandom());
        p.coord_y = 16'($urandom());
        case (kind)
            5:
            begin
                p.coord_x = 16'($urandom_range(0, 32) - 16);
                p.coord_y = 16'($urandom_range(0, 32) - 16);
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                    p.coord_x = '0;
                else
                    p.coord_y = '0;
            end
            7:
            begin
                p.coord_x = 16'(corner[$urandom_range(0, 5)]);
                p.coord_y = 16'(corner[$urandom_range(0, 5)]);
            end
            8:
                p.coord_y = ($urandom_range(0, 1) == 0) ? p.coord_x : -p.coord_x;
            9:
            begin
                p.coord_x = 16'(-int'($urandom_range(1, 32768)));
                p.coord_y = 16'($urandom_range(0, 4) - 2);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // offer one beat, with a burst/gap pattern on the sender side
    task automatic send_point(input point_t p, input bit typed, input polar_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        point      <= p;
        start      <= 1'b1;
        typed_ok   <= typed;
        typed_want <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    always @(posedge clk)
    begin
        polar_t want;
        if (done)
        begin
            if (polar_q.size() == 0)
                flag_fault($sformatf("unexpected beat mag=%0d ang=%0d",
                                     result.magnitude, result.angle));
            else
            begin
                want = polar_q.pop_front();
                checked++;
                if (result.magnitude !== want.magnitude)
                    flag_fault($sformatf("beat %0d magnitude exp=%0d got=%0d",
                                         checked, want.magnitude, result.magnitude));
                if (result.angle !== want.angle)
                    flag_fault($sformatf("beat %0d angle exp=%0d got=%0d",
                                         checked, want.angle, result.angle));
            end
        end
        if (rst_n && start && !busy)
        begin
            polar_q.push_back(typed_ok ? typed_want : cordic_polar(point));
            accepted++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, polar_q.size());
            $display("cartesian_to_polar verification failed");
            $finish;
        end
    end

    initial
    begin
        point_t p;
        polar_t want;
        int     n;
        gain_q20 = cordic_inv_gain();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
        begin
            p.coord_x      = 16'(directed_rows[n].x);
            p.coord_y      = 16'(directed_rows[n].y);
            want.magnitude = 16'(directed_rows[n].mag);
            want.angle     = 16'(directed_rows[n].ang);
            send_point(p, directed_rows[n].typed, want);
        end

        for (n = 0; n < RANDOM_PTS; n++)
            send_point(random_point(), 1'b0, '0);

        start <= 1'b0;
        while (polar_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Converted %0d points (%0d directed, %0d random) in %0d cycles.",
                 accepted, DIR_ROWS, RANDOM_PTS, cycle_count);
        $display("Checked %0d results across all quadrants and axes, %0d faults.",
                 checked, fault_count);
        if (fault_count == 0 && checked == accepted)
            $display("cartesian_to_polar verification clean");
        else
            $display("cartesian_to_polar verification failed");
        $finish;
    end

endmodule
